@@ design/bds_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int PIXEL_W    = 32;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  // each byte lane shifted right by two keeps six bits
  localparam logic [PIXEL_W-1:0] LANE_MASK = 32'h3F3F3F3F;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 12'd320;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 12'd240;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;

  // position of the pixel under the scan counters
  typedef struct packed {
    logic col_odd;
    logic row_odd;
    logic frame_last;
  } scan_t;

endpackage
`default_nettype wire

@@ design/box_downsample_2x2_rgba.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// box_downsample_2x2_rgba
// 2x2 box-filter downsampler for a packed four-channel pixel stream.
// ----------------------------------------------------------------------------
// Throughput: one source pixel per clock while the output is not stalled.
// Output path: the line buffer read and the pair sum of a closing pixel are
//   registered in stage 1, then their sum goes into the output register once it is free.
// Reset: geometry returns to 320 x 240 and the frame restarts at its first
//   pixel; the line buffer is not cleared, every entry is written before use.
module box_downsample_2x2_rgba #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire                             clk,
  input  wire                             rst,
  // configuration write channel
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [bds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [bds_pkg::CFG_DATA_W-1:0]  cfg_data,
  // source pixels
  input  wire                             s_tvalid,
  output logic                            s_tready,
  input  wire  [bds_pkg::PIXEL_W-1:0]     s_tdata,   // [31:0] pixel_in
  // downsampled pixels
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [bds_pkg::PIXEL_W-1:0]     m_tdata,   // [31:0] pixel_out
  output logic                            m_tlast    // frame_end
);
  import bds_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = $clog2(DEPTH);

  logic               accept;
  logic [CW-1:0]      col;
  scan_t              info;
  logic [AW-1:0]      slot;
  logic [PIXEL_W-1:0] quarter;
  logic [PIXEL_W-1:0] left_partial;
  logic [PIXEL_W-1:0] pair_sum;
  logic               line_write;
  logic               line_read;
  logic [PIXEL_W-1:0] line_data;

  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pair;
  logic               s1_last;
  logic               out_free;
  logic               s1_move;

  assign cfg_ready = 1'b1;

  assign out_free = !m_tvalid || m_tready;
  assign s1_move  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  bds_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .col       (col),
    .info      (info)
  );

  // pre-shift each lane so four terms never carry into the next lane
  assign quarter  = (s_tdata >> 2) & LANE_MASK;
  assign pair_sum = left_partial + quarter;
  assign slot     = col[AW:1];

  assign line_write = accept && info.col_odd && !info.row_odd;
  assign line_read  = accept && info.col_odd && info.row_odd;

  bds_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_pair_line (
    .clk     (clk),
    .wr_en   (line_write),
    .wr_addr (slot),
    .wr_data (pair_sum),
    .rd_en   (line_read),
    .rd_addr (slot),
    .rd_data (line_data)
  );

  // hold the even-column pixel of the current pair
  always_ff @(posedge clk) begin
    if (accept && !info.col_odd) begin
      left_partial <= quarter;
    end
  end

  // stage 1: wait for the line buffer read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (line_read) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_read) begin
      s1_pair <= pair_sum;
      s1_last <= info.frame_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= line_data + s1_pair;
      m_tlast <= s1_last;
    end
  end

endmodule
`default_nettype wire

@@ design/bds_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bds_ram
// Simple dual-port RAM, one write port, one read port with registered read.
// ----------------------------------------------------------------------------
module bds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]         wr_data,
  input  wire                      rd_en,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/bds_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bds_scan
// Frame geometry registers and the column / row scan counters.
// ----------------------------------------------------------------------------
module bds_scan #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_write,
  input  wire  [bds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [bds_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire                               advance,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output bds_pkg::scan_t                    info
);
  import bds_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WDW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                       $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
  localparam int HDW = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                       $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] source_width;
  logic [CFG_DATA_W-1:0] source_height;
  logic [RW-1:0]         row;
  logic [CW-1:0]         col_next;
  logic [RW-1:0]         row_next;

  logic [WDW-1:0] w_raw, w_eff, last_col, col_ext;
  logic [HDW-1:0] h_raw, h_eff, last_row, row_ext;
  logic           col_wrap, row_wrap;

  assign w_raw   = WDW'(source_width);
  assign h_raw   = HDW'(source_height);
  assign col_ext = WDW'(col);
  assign row_ext = HDW'(row);

  // clamp the geometry to the legal range
  always_comb begin
    priority if (w_raw < WDW'(2)) begin
      w_eff = WDW'(2);
    end else if (w_raw > WDW'(MAX_WIDTH)) begin
      w_eff = WDW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    priority if (h_raw < HDW'(2)) begin
      h_eff = HDW'(2);
    end else if (h_raw > HDW'(MAX_HEIGHT)) begin
      h_eff = HDW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // last odd column and row that complete a 2x2 block
  assign last_col = {w_eff[WDW-1:1], 1'b0} - WDW'(1);
  assign last_row = {h_eff[HDW-1:1], 1'b0} - HDW'(1);

  assign col_wrap = (col_ext + WDW'(1)) >= w_eff;
  assign row_wrap = (row_ext + HDW'(1)) >= h_eff;

  always_comb begin
    col_next = col + CW'(1);
    row_next = row;
    if (col_wrap) begin
      col_next = '0;
      row_next = row_wrap ? '0 : row + RW'(1);
    end
  end

  assign info.col_odd    = col[0];
  assign info.row_odd    = row[0];
  assign info.frame_last = (col_ext == last_col) && (row_ext == last_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= WIDTH_RESET;
      source_height <= HEIGHT_RESET;
      col           <= '0;
      row           <= '0;
    end else if (cfg_write &&
                 (cfg_index == CFG_SOURCE_WIDTH || cfg_index == CFG_SOURCE_HEIGHT)) begin
      // any geometry write restarts the frame
      unique case (cfg_index)
        CFG_SOURCE_WIDTH:  source_width  <= cfg_data;
        CFG_SOURCE_HEIGHT: source_height <= cfg_data;
        default:           source_width  <= source_width;
      endcase
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2 box downsampler. A shadow model tracks the
// scan position, geometry and line buffer, predicts every averaged pixel and
// its frame-end flag, and a monitor compares each output request in order.
// Covers pixel extremes, odd last column and row, clamped geometry, writes to
// unused register indexes, geometry above the maximum, and random frames
// with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import bds_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIM_MAX      = 2048;
  localparam int LINE_SLOTS   = DIM_MAX / 2;
  localparam int RANDOM_ITEMS = 950;
  localparam int REPORT_CAP   = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PIXEL_W-1:0]    s_tdata;   // [31:0] pixel_in
  logic                  m_tvalid;
  logic                  m_tready;
  logic [PIXEL_W-1:0]    m_tdata;   // [31:0] pixel_out
  logic                  m_tlast;   // frame_end

  box_downsample_2x2_rgba dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_end;
  } averaged_t;

  averaged_t awaited_pixels[$];

  // shadow of the block state
  logic [CFG_DATA_W-1:0] geo_width  = WIDTH_RESET;
  logic [CFG_DATA_W-1:0] geo_height = HEIGHT_RESET;
  logic [10:0]           scan_col   = '0;
  logic [10:0]           scan_row   = '0;
  logic [PIXEL_W-1:0]    left_quarter;
  logic [PIXEL_W-1:0]    pair_sums [LINE_SLOTS];

  int  pixels_sent;
  int  results_seen;
  int  frame_ends_seen;
  int  settings_used;
  int  mismatch_count;
  bit  source_calm;
  bit  sink_calm;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 2_000_000);
    $display("FAILURE");
    $finish;
  end

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [11:0] usable_dim(input logic [CFG_DATA_W-1:0] v);
    if (v < 12'd2) return 12'd2;
    if (v > DIM_MAX) return 12'(DIM_MAX);
    return v;
  endfunction

  function automatic logic [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) $display("%0t: %s", $time, what);
    else if (mismatch_count == REPORT_CAP + 1) $display("further mismatches not shown");
  endtask

  // Advance the shadow scan by one source pixel and queue the result it closes.
  task automatic downsample_pixel(input logic [PIXEL_W-1:0] pix);
    logic [11:0]        w, h, last_col, last_row;
    logic [PIXEL_W-1:0] q;
    averaged_t          res;
    w = usable_dim(geo_width);
    h = usable_dim(geo_height);
    last_col = {w[11:1], 1'b0} - 12'd1;
    last_row = {h[11:1], 1'b0} - 12'd1;
    q = (pix >> 2) & LANE_MASK;
    if ({1'b0, scan_col} <= last_col && {1'b0, scan_row} <= last_row + 12'd1) begin
      if (!scan_col[0]) begin
        left_quarter = q;
      end else if (!scan_row[0]) begin
        pair_sums[scan_col[10:1]] = left_quarter + q;
      end else if ({1'b0, scan_row} <= last_row) begin
        res.pixel     = pair_sums[scan_col[10:1]] + left_quarter + q;
        res.frame_end = ({1'b0, scan_col} == last_col) && ({1'b0, scan_row} == last_row);
        awaited_pixels.push_back(res);
      end
    end
    if ({1'b0, scan_col} + 12'd1 >= w) begin
      scan_col = '0;
      scan_row = ({1'b0, scan_row} + 12'd1 >= h) ? 11'd0 : scan_row + 11'd1;
    end else begin
      scan_col = scan_col + 11'd1;
    end
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
    int gap;
    gap = draw_wait(source_calm);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = pix;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
    downsample_pixel(pix);
  endtask

  task automatic stop_source();
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    stop_source();
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SOURCE_WIDTH || idx == CFG_SOURCE_HEIGHT) begin
      if (idx == CFG_SOURCE_WIDTH) geo_width = value;
      else geo_height = value;
      // any geometry write restarts the frame
      scan_col = '0;
      scan_row = '0;
      settings_used++;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_register(CFG_SOURCE_WIDTH, w);
    write_register(CFG_SOURCE_HEIGHT, h);
  endtask

  // monitor: compare every accepted output request with the oldest prediction
  always @(posedge clk) begin : check_results
    averaged_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_pixels.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: expected none, got %h frame_end %b",
                                m_tdata, m_tlast));
      end else begin
        want = awaited_pixels.pop_front();
        results_seen++;
        if (m_tlast) frame_ends_seen++;
        if (m_tdata !== want.pixel)
          flag_mismatch($sformatf("pixel_out: expected %h, got %h", want.pixel, m_tdata));
        if (m_tlast !== want.frame_end)
          flag_mismatch($sformatf("frame_end: expected %b, got %b", want.frame_end, m_tlast));
      end
    end
  end

  // sink: stall a random number of cycles before taking each result
  initial begin : sink_side
    int stall;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = draw_wait(sink_calm);
      repeat (stall) begin
        @(negedge clk);
        m_tready = 1'b0;
      end
      @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // reset geometry is 320 wide: two rows give a full line of results
  task automatic test_default_geometry();
    repeat (2 * 320) send_pixel(random_pixel());
  endtask

  task automatic test_directed_corners();
    // all-zero block, then all-ones block; low bits of each lane are discarded
    set_geometry(12'd4, 12'd2);
    repeat (2) begin
      send_pixel(32'h0000_0000);
      send_pixel(32'h0303_0303);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'hFFFF_FFFF);
    end
    // odd last column and odd last row hold ones and must not leak
    set_geometry(12'd3, 12'd3);
    send_pixel(32'h8040_2010);
    send_pixel(32'h0102_0408);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h7F7F_7F7F);
    send_pixel(32'hC0C0_C0C0);
    send_pixel(32'hFFFF_FFFF);
    repeat (3) send_pixel(32'hFFFF_FFFF);
    // dimensions below range act as 2
    set_geometry(12'd1, 12'd0);
    repeat (4) send_pixel(random_pixel());
  endtask

  // writes to indexes with no register must not restart the frame
  task automatic test_unused_index();
    set_geometry(12'd4, 12'd4);
    repeat (6) send_pixel(random_pixel());
    write_register(CFG_UNUSED_LOW, 12'hFFF);
    write_register(CFG_UNUSED_HIGH, 12'h000);
    repeat (10) send_pixel(random_pixel());
  endtask

  // dimensions above the maximum act as the maximum
  task automatic test_oversize_geometry();
    set_geometry(12'hFFF, 12'hFFF);
    repeat (100) send_pixel(random_pixel());
    set_geometry(12'd2, 12'hFFF);
    repeat (100) send_pixel(random_pixel());
  endtask

  task automatic test_random_frames();
    int sent, count, frame_size;
    logic [CFG_DATA_W-1:0] w, h;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = CFG_DATA_W'($urandom_range(0, 1));
        1:       w = CFG_DATA_W'($urandom_range(13, 64));
        default: w = CFG_DATA_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       h = CFG_DATA_W'($urandom_range(0, 1));
        1:       h = CFG_DATA_W'($urandom_range(8, 20));
        default: h = CFG_DATA_W'($urandom_range(2, 7));
      endcase
      case ($urandom_range(0, 5))
        0: ;  // keep geometry, carry on mid-frame
        1: write_register(CFG_SOURCE_HEIGHT, h);
        2: write_register(CFG_SOURCE_WIDTH, w);
        default: set_geometry(w, h);
      endcase
      source_calm = ($urandom_range(0, 3) == 0);
      sink_calm   = ($urandom_range(0, 3) == 0);
      frame_size = usable_dim(geo_width) * usable_dim(geo_height);
      count = frame_size * $urandom_range(1, 3) + $urandom_range(0, frame_size - 1);
      if (count > 400) count = 400;
      for (int i = 0; i < count; i++) begin
        send_pixel(random_pixel());
        // hold the source until every pending result has drained
        if ($urandom_range(0, 59) == 0) begin
          stop_source();
          wait_idle();
        end
      end
      sent += count;
    end
    source_calm = 1'b0;
    sink_calm   = 1'b0;
  endtask

  initial begin : run_tests
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_geometry();
    test_directed_corners();
    test_unused_index();
    test_oversize_geometry();
    test_random_frames();

    stop_source();
    wait_idle();
    if (awaited_pixels.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_pixels.size()));

    $display("Sent %0d source pixels across %0d geometry writes, incl. clamped sizes.",
             pixels_sent, settings_used);
    $display("Checked %0d averaged pixels, %0d of them closing a frame.",
             results_seen, frame_ends_seen);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
